### hdl/dspwm_pkg.sv
package dspwm_pkg;

    // Field widths fixed by the stream format
    localparam int CFG_BITS   = 16;
    localparam int SET_BITS   = 16;
    localparam int OP_BITS    = 2;
    localparam int STATE_BITS = 2;
    localparam int IDX_BITS   = 2;

    // Defaults for the top-level parameters
    localparam int MOTOR_COUNT_DEFAULT = 2;
    localparam int DUTY_BITS_DEFAULT   = 16;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SET_STATE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_TRIM      = 2'd2;

    // Run states
    localparam logic [STATE_BITS-1:0] RS_STOPPED  = 2'd0;
    localparam logic [STATE_BITS-1:0] RS_FORWARD  = 2'd1;
    localparam logic [STATE_BITS-1:0] RS_BACKWARD = 2'd2;
    localparam logic [STATE_BITS-1:0] RS_RESERVED = 2'd3;

    // Configuration register indexes
    localparam logic [IDX_BITS-1:0] REG_PERIOD_RELOAD = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_TRIM_FLOOR    = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_TRIM_CEILING  = 2'd2;
    localparam logic [IDX_BITS-1:0] REG_LEFT_MIRRORED = 2'd3;

    // Reset values
    localparam logic [31:0] PERIOD_RELOAD_RESET = 32'd47103;
    localparam logic [31:0] TRIM_FLOOR_RESET    = 32'd18432;
    localparam logic [31:0] TRIM_CEILING_RESET  = 32'd65535;
    localparam logic        LEFT_MIRRORED_RESET = 1'b1;
    localparam logic [31:0] FWD_RESET_LEFT      = 32'd48140;
    localparam logic [31:0] BWD_RESET_LEFT      = 32'd48690;
    localparam logic [31:0] FWD_RESET_RIGHT     = 32'd48930;
    localparam logic [31:0] BWD_RESET_RIGHT     = 32'd47990;

    typedef struct packed {
        logic [CFG_BITS-1:0] period_reload;
        logic [CFG_BITS-1:0] trim_floor;
        logic [CFG_BITS-1:0] trim_ceiling;
        logic                left_mirrored;
    } cfg_t;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic                  motor;
        logic [STATE_BITS-1:0] run_state;
        logic                  trim_direction;
        logic                  speed_up;
    } item_t;

    typedef struct packed {
        logic                left_pin;
        logic                right_pin;
        logic                period_start;
        logic [SET_BITS-1:0] forward_setting;
        logic [SET_BITS-1:0] backward_setting;
        logic                save_request;
        logic [1:0]          save_slot;
        logic [SET_BITS-1:0] save_value;
    } result_t;

endpackage

### hdl/dual_servo_pwm_with_trim.sv
// Two-channel servo PWM generator with per-motor speed trim. Every input
// transaction (tick, set run state, trim or the unused op) yields exactly
// one result transaction. One transaction is taken per clock cycle. An
// accepted transaction is loaded into the input register, and its result
// then into the result register, which drives the result stream. The
// pipeline only halts while the result register is full and m_tready is
// low. Configuration registers are written through cfg_wr_en/cfg_index/
// cfg_data and must only change while the block is idle.
// The pin levels, period-start flag and addressed motor's duty settings in
// each result reflect the state after that transaction.
module dual_servo_pwm_with_trim #(
    parameter int MOTOR_COUNT = dspwm_pkg::MOTOR_COUNT_DEFAULT,
    parameter int DUTY_BITS   = dspwm_pkg::DUTY_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // motor, run_state[1:0],
                                                       // trim_direction, speed_up
    input  logic [dspwm_pkg::OP_BITS-1:0]    s_tuser,  // op
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [55:0]                      m_tdata,  // left_pin, right_pin,
                                                       // period_start,
                                                       // forward_setting[15:0],
                                                       // backward_setting[15:0],
                                                       // save_request,
                                                       // save_slot[1:0],
                                                       // save_value[15:0]
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [dspwm_pkg::IDX_BITS-1:0]   cfg_index,
    input  logic [dspwm_pkg::CFG_BITS-1:0]   cfg_data
);
    import dspwm_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t res_reg;
    result_t res;
    logic    advance;
    logic    step_en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_reload <= CFG_BITS'(PERIOD_RELOAD_RESET);
            cfg_reg.trim_floor    <= CFG_BITS'(TRIM_FLOOR_RESET);
            cfg_reg.trim_ceiling  <= CFG_BITS'(TRIM_CEILING_RESET);
            cfg_reg.left_mirrored <= LEFT_MIRRORED_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_PERIOD_RELOAD: cfg_reg.period_reload <= cfg_data;
                REG_TRIM_FLOOR:    cfg_reg.trim_floor    <= cfg_data;
                REG_TRIM_CEILING:  cfg_reg.trim_ceiling  <= cfg_data;
                REG_LEFT_MIRRORED: cfg_reg.left_mirrored <= cfg_data[0];
            endcase
        end
    end

    // Pipeline moves when the result register is empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op             <= s_tuser;
            item_reg.motor          <= s_tdata[0];
            item_reg.run_state      <= s_tdata[2:1];
            item_reg.trim_direction <= s_tdata[3];
            item_reg.speed_up       <= s_tdata[4];
        end
    end

    dspwm_engine #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .DUTY_BITS   (DUTY_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       res_reg.save_value,
                       res_reg.save_slot,
                       res_reg.save_request,
                       res_reg.backward_setting,
                       res_reg.forward_setting,
                       res_reg.period_start,
                       res_reg.right_pin,
                       res_reg.left_pin};

endmodule

### hdl/dspwm_engine.sv
module dspwm_engine #(
    parameter int MOTOR_COUNT = dspwm_pkg::MOTOR_COUNT_DEFAULT,
    parameter int DUTY_BITS   = dspwm_pkg::DUTY_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  dspwm_pkg::item_t  item,
    input  dspwm_pkg::cfg_t   cfg,
    output dspwm_pkg::result_t res
);
    import dspwm_pkg::*;

    // Compare width wide enough for both duties and limit registers
    localparam int CW        = (DUTY_BITS > CFG_BITS) ? DUTY_BITS : CFG_BITS;
    localparam int RIGHT_IDX = (MOTOR_COUNT > 1) ? 1 : 0;
    localparam logic RIGHT_PRESENT = (MOTOR_COUNT > 1);

    logic [DUTY_BITS-1:0]  counter_reg, counter_next;
    logic [DUTY_BITS-1:0]  fwd_reg [MOTOR_COUNT];
    logic [DUTY_BITS-1:0]  fwd_next [MOTOR_COUNT];
    logic [DUTY_BITS-1:0]  bwd_reg [MOTOR_COUNT];
    logic [DUTY_BITS-1:0]  bwd_next [MOTOR_COUNT];
    logic [DUTY_BITS-1:0]  act_reg [MOTOR_COUNT];
    logic [DUTY_BITS-1:0]  act_next [MOTOR_COUNT];
    logic [DUTY_BITS-1:0]  cmp_reg [MOTOR_COUNT];
    logic [DUTY_BITS-1:0]  cmp_next [MOTOR_COUNT];
    logic [STATE_BITS-1:0] state_reg [MOTOR_COUNT];
    logic [STATE_BITS-1:0] state_next [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] armed_reg, armed_next;
    logic [MOTOR_COUNT-1:0] pin_reg, pin_next;

    logic                 wrap;
    logic                 is_tick;
    logic                 is_set;
    logic                 is_trim;
    logic                 motor_ok;
    logic                 mir;
    logic                 inc;
    logic [DUTY_BITS-1:0] cur;
    logic [DUTY_BITS-1:0] newv;
    logic [DUTY_BITS-1:0] save_val;
    logic [DUTY_BITS-1:0] fwd_sel;
    logic [DUTY_BITS-1:0] bwd_sel;

    // Step logic: tick, run-state change and trim
    always_comb
    begin
        counter_next = counter_reg;
        fwd_next     = fwd_reg;
        bwd_next     = bwd_reg;
        act_next     = act_reg;
        cmp_next     = cmp_reg;
        state_next   = state_reg;
        armed_next   = armed_reg;
        pin_next     = pin_reg;
        mir          = 1'b0;
        inc          = 1'b0;
        cur          = '0;
        newv         = '0;
        save_val     = '0;
        fwd_sel      = '0;
        bwd_sel      = '0;

        wrap     = &counter_reg;
        motor_ok = (item.motor == 1'b0) || RIGHT_PRESENT;
        is_tick  = step_en && (item.op == OP_TICK);
        is_set   = step_en && (item.op == OP_SET_STATE) && motor_ok;
        is_trim  = step_en && (item.op == OP_TRIM) && motor_ok;

        // period counter: count up, reload after the all-ones count
        if (is_tick)
        begin
            if (wrap)
                counter_next = DUTY_BITS'(cfg.period_reload);
            else
                counter_next = counter_reg + 1'b1;
        end

        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            // latch active duty at period start
            if (is_tick && wrap)
            begin
                cmp_next[m]   = act_reg[m];
                armed_next[m] = (act_reg[m] != '0) &&
                                (CW'(act_reg[m]) < CW'(cfg.trim_ceiling));
                pin_next[m]   = (act_reg[m] != '0);
            end
            // falling edge on compare match, reload tick included
            if (is_tick && armed_next[m] && (counter_next == cmp_next[m]))
                pin_next[m] = 1'b0;

            if (int'(item.motor) == m)
            begin
                if (is_set)
                begin
                    if (item.run_state == RS_RESERVED)
                        state_next[m] = RS_STOPPED;
                    else
                        state_next[m] = item.run_state;
                end

                if (is_trim)
                begin
                    mir = (m == 0) ? cfg.left_mirrored : 1'b0;
                    inc = item.speed_up ^ item.trim_direction ^ mir;
                    cur = item.trim_direction ? bwd_reg[m] : fwd_reg[m];
                    newv = cur;
                    if (inc)
                    begin
                        if (CW'(cur) < CW'(cfg.trim_ceiling))
                            newv = cur + 1'b1;
                    end
                    else
                    begin
                        if (CW'(cur) > CW'(cfg.trim_floor))
                            newv = cur - 1'b1;
                    end
                    if (item.trim_direction)
                        bwd_next[m] = newv;
                    else
                        fwd_next[m] = newv;
                    save_val = newv;
                end

                // refresh active duty from the new state and duties
                if (is_set || is_trim)
                begin
                    case (state_next[m])
                        RS_FORWARD:  act_next[m] = fwd_next[m];
                        RS_BACKWARD: act_next[m] = bwd_next[m];
                        default:     act_next[m] = '0;
                    endcase
                end

                fwd_sel = fwd_next[m];
                bwd_sel = bwd_next[m];
            end
        end

        // result of this step
        res.left_pin         = pin_next[0];
        res.right_pin        = RIGHT_PRESENT && pin_next[RIGHT_IDX];
        res.period_start     = is_tick && wrap;
        res.forward_setting  = SET_BITS'(fwd_sel);
        res.backward_setting = SET_BITS'(bwd_sel);
        res.save_request     = is_trim;
        res.save_slot        = is_trim ? {item.motor, item.trim_direction} : 2'd0;
        res.save_value       = is_trim ? SET_BITS'(save_val) : '0;
    end

    // Channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= DUTY_BITS'(PERIOD_RELOAD_RESET);
            armed_reg   <= '0;
            pin_reg     <= '0;
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                fwd_reg[m]   <= (m == 0) ? DUTY_BITS'(FWD_RESET_LEFT) :
                                (m == 1) ? DUTY_BITS'(FWD_RESET_RIGHT) : '0;
                bwd_reg[m]   <= (m == 0) ? DUTY_BITS'(BWD_RESET_LEFT) :
                                (m == 1) ? DUTY_BITS'(BWD_RESET_RIGHT) : '0;
                act_reg[m]   <= '0;
                cmp_reg[m]   <= '0;
                state_reg[m] <= RS_STOPPED;
            end
        end
        else
        begin
            counter_reg <= counter_next;
            fwd_reg     <= fwd_next;
            bwd_reg     <= bwd_next;
            act_reg     <= act_next;
            cmp_reg     <= cmp_next;
            state_reg   <= state_next;
            armed_reg   <= armed_next;
            pin_reg     <= pin_next;
        end
    end

`ifndef NO_ASSERTIONS
    // a save is only raised by a trim transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        res.save_request |-> (step_en && item.op == OP_TRIM))
        else $error("save request without trim");

    // period start leaves the counter at the reload value
    assert property (@(posedge clk) disable iff (!rst_n)
        res.period_start |=> counter_reg == DUTY_BITS'($past(cfg.period_reload)))
        else $error("counter not reloaded at period start");

    // an ordinary tick advances the counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (is_tick && !wrap) |=> counter_reg == $past(counter_reg) + 1'b1)
        else $error("counter did not advance");

    // only ticks move the counter
    assert property (@(posedge clk) disable iff (!rst_n)
        !is_tick |=> $stable(counter_reg))
        else $error("counter moved without a tick");
`endif

endmodule

### bench/tb_dual_servo_pwm_with_trim.sv
`timescale 1ns / 1ps

module tb_dual_servo_pwm_with_trim;

    import dspwm_pkg::*;

    localparam int  HALF_PERIOD   = 5;
    localparam int  RESET_CYCLES  = 9;
    localparam int  IDLE_PERCENT  = 36;
    localparam int  HOLD_CYCLES   = 200;
    localparam int  STALL_LIMIT   = 3000;
    localparam int  DRAIN_CYCLES  = 4;
    localparam int  REPORT_MAX    = 10;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam logic [15:0] DUTY_FULL = 16'hFFFF;

    // One row of the directed table: the transaction, and a typed-in result
    // where the outcome is obvious
    typedef struct {
        item_t   it;
        bit      fixed;
        result_t res;
    } stim_row_s;

    typedef struct {
        item_t   it;
        bit      fixed;
        result_t res;
    } queued_item_s;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;  // motor, run_state[1:0], trim_direction, speed_up
    logic [OP_BITS-1:0]    s_tuser;  // op
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;  // left_pin, right_pin, period_start,
                                     // forward_setting[15:0], backward_setting[15:0],
                                     // save_request, save_slot[1:0], save_value[15:0]
    logic                  cfg_wr_en;
    logic [IDX_BITS-1:0]   cfg_index;
    logic [CFG_BITS-1:0]   cfg_data;

    dual_servo_pwm_with_trim dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the generator state and registers
    logic [15:0]           sh_counter;
    logic [15:0]           sh_fwd     [2];
    logic [15:0]           sh_bwd     [2];
    logic [15:0]           sh_active  [2];
    logic [15:0]           sh_compare [2];
    logic [STATE_BITS-1:0] sh_state   [2];
    bit                    sh_armed   [2];
    bit                    sh_pin     [2];
    logic [15:0]           sh_reload;
    logic [15:0]           sh_floor;
    logic [15:0]           sh_ceiling;
    bit                    sh_mirrored;

    queued_item_s servo_items_todo [$];
    result_t      servo_results_due [$];
    queued_item_s item_on_bus;
    int           items_in_flight;
    int           mismatch_count;
    int           stall_cycles;
    bit           calm;
    int           hold_requests;
    int           hold_served;
    int           hold_left;

    // Directed rows, reset configuration (left side mirrored)
    stim_row_s dir_rows [20] = '{
        // first tick after reset: nothing latched yet, pins low
        '{'{OP_TICK, 1'b0, RS_STOPPED, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 1'b0, 1'b0, FWD_RESET_LEFT[15:0], BWD_RESET_LEFT[15:0],
            1'b0, 2'd0, 16'd0}},
        // unused op leaves everything alone
        '{'{OP_UNUSED, 1'b1, RS_STOPPED, 1'b0, 1'b0}, 1'b1,
          '{1'b0, 1'b0, 1'b0, FWD_RESET_RIGHT[15:0], BWD_RESET_RIGHT[15:0],
            1'b0, 2'd0, 16'd0}},
        // mirrored left motor: speed up on the forward duty steps it down
        '{'{OP_TRIM, 1'b0, RS_STOPPED, 1'b0, 1'b1}, 1'b1,
          '{1'b0, 1'b0, 1'b0, 16'd48139, BWD_RESET_LEFT[15:0],
            1'b1, 2'd0, 16'd48139}},
        '{'{OP_TRIM, 1'b0, RS_STOPPED, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_TRIM, 1'b0, RS_STOPPED, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_TRIM, 1'b0, RS_STOPPED, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_TRIM, 1'b1, RS_STOPPED, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_TRIM, 1'b1, RS_STOPPED, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_TRIM, 1'b1, RS_STOPPED, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_TRIM, 1'b1, RS_STOPPED, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_SET_STATE, 1'b0, RS_FORWARD, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_SET_STATE, 1'b1, RS_BACKWARD, 1'b0, 1'b0}, 1'b0, '0},
        // reserved run state falls back to stopped
        '{'{OP_SET_STATE, 1'b0, RS_RESERVED, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_SET_STATE, 1'b0, RS_BACKWARD, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_SET_STATE, 1'b1, RS_STOPPED, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_SET_STATE, 1'b1, RS_FORWARD, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_TICK, 1'b0, RS_STOPPED, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_UNUSED, 1'b0, RS_RESERVED, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_TRIM, 1'b1, RS_RESERVED, 1'b1, 1'b1}, 1'b0, '0},
        // tick with every spare bit set
        '{'{OP_TICK, 1'b1, RS_RESERVED, 1'b1, 1'b1}, 1'b0, '0}
    };

    always #HALF_PERIOD clk = ~clk;

    task automatic reset_shadow();
        sh_counter  = PERIOD_RELOAD_RESET[15:0];
        sh_fwd[0]   = FWD_RESET_LEFT[15:0];
        sh_bwd[0]   = BWD_RESET_LEFT[15:0];
        sh_fwd[1]   = FWD_RESET_RIGHT[15:0];
        sh_bwd[1]   = BWD_RESET_RIGHT[15:0];
        sh_reload   = PERIOD_RELOAD_RESET[15:0];
        sh_floor    = TRIM_FLOOR_RESET[15:0];
        sh_ceiling  = TRIM_CEILING_RESET[15:0];
        sh_mirrored = LEFT_MIRRORED_RESET;
        for (int m = 0; m < 2; m++)
        begin
            sh_active[m]  = '0;
            sh_compare[m] = '0;
            sh_state[m]   = RS_STOPPED;
            sh_armed[m]   = 1'b0;
            sh_pin[m]     = 1'b0;
        end
    endtask

    function automatic logic [15:0] duty_for_state(int m);
        case (sh_state[m])
            RS_FORWARD:  return sh_fwd[m];
            RS_BACKWARD: return sh_bwd[m];
            default:     return 16'd0;
        endcase
    endfunction

    // Advance the shadow state by one transaction and form its result
    task automatic predict_servo_step(input item_t it, output result_t r);
        int          m;
        bit          wrap;
        bit          inc;
        logic [15:0] v;
        m = it.motor;
        r = '0;
        case (it.op)
            OP_TICK:
            begin
                wrap = (sh_counter == DUTY_FULL);
                r.period_start = wrap;
                if (wrap)
                begin
                    sh_counter = sh_reload;
                    for (int k = 0; k < 2; k++)
                    begin
                        sh_compare[k] = sh_active[k];
                        sh_armed[k]   = (sh_active[k] != 0) && (sh_active[k] < sh_ceiling);
                        sh_pin[k]     = (sh_active[k] != 0);
                    end
                end
                else
                begin
                    sh_counter = sh_counter + 16'd1;
                end
                // compare also applies to the freshly reloaded count
                for (int k = 0; k < 2; k++)
                    if (sh_armed[k] && sh_counter == sh_compare[k])
                        sh_pin[k] = 1'b0;
            end
            OP_SET_STATE:
            begin
                sh_state[m]  = (it.run_state == RS_RESERVED) ? RS_STOPPED : it.run_state;
                sh_active[m] = duty_for_state(m);
            end
            OP_TRIM:
            begin
                v   = it.trim_direction ? sh_bwd[m] : sh_fwd[m];
                inc = it.speed_up ^ it.trim_direction ^ ((m == 0) ? sh_mirrored : 1'b0);
                if (inc)
                begin
                    if (v < sh_ceiling)
                        v = v + 16'd1;
                end
                else if (v > sh_floor)
                begin
                    v = v - 16'd1;
                end
                if (it.trim_direction)
                    sh_bwd[m] = v;
                else
                    sh_fwd[m] = v;
                sh_active[m]   = duty_for_state(m);
                r.save_request = 1'b1;
                r.save_slot    = {it.motor, it.trim_direction};
                r.save_value   = v;
            end
            default: ;
        endcase
        r.left_pin         = sh_pin[0];
        r.right_pin        = sh_pin[1];
        r.forward_setting  = sh_fwd[m];
        r.backward_setting = sh_bwd[m];
    endtask

    task automatic queue_item(input item_t it, input bit fixed, input result_t res);
        queued_item_s q;
        q.it    = it;
        q.fixed = fixed;
        q.res   = res;
        servo_items_todo.push_back(q);
        items_in_flight++;
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PERIOD_RELOAD: sh_reload   = val;
            REG_TRIM_FLOOR:    sh_floor    = val;
            REG_TRIM_CEILING:  sh_ceiling  = val;
            default:           sh_mirrored = val[0];
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (items_in_flight != 0 || servo_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random transactions with a given mix of ops (percent weights)
    task automatic queue_random(input int n, input int w_tick, input int w_set,
                                input int w_trim, input bit left_sets_only);
        item_t it;
        int    pick;
        for (int i = 0; i < n; i++)
        begin
            it.motor          = $urandom_range(0, 1);
            it.run_state      = $urandom_range(0, 3);
            it.trim_direction = $urandom_range(0, 1);
            it.speed_up       = $urandom_range(0, 1);
            pick = $urandom_range(0, 99);
            if (pick < w_tick)
                it.op = OP_TICK;
            else if (pick < w_tick + w_set)
            begin
                it.op = OP_SET_STATE;
                if (left_sets_only)
                    it.motor = 1'b0;
            end
            else if (pick < w_tick + w_set + w_trim)
                it.op = OP_TRIM;
            else
                it.op = OP_UNUSED;
            queue_item(it, 1'b0, '0);
        end
    endtask

    // Sender: one transaction at a time, random gaps
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_servo_step(item_on_bus.it, r);
                servo_results_due.push_back(item_on_bus.fixed ? item_on_bus.res : r);
                items_in_flight--;
            end
            if (!s_tvalid || s_tready)
            begin
                if (servo_items_todo.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    item_on_bus = servo_items_todo.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item_on_bus.it.op;
                    s_tdata  <= {3'b000, item_on_bus.it.speed_up,
                                 item_on_bus.it.trim_direction,
                                 item_on_bus.it.run_state, item_on_bus.it.motor};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure plus requested long hold-offs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_requests != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        bit      bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.left_pin         = m_tdata[0];
            got.right_pin        = m_tdata[1];
            got.period_start     = m_tdata[2];
            got.forward_setting  = m_tdata[18:3];
            got.backward_setting = m_tdata[34:19];
            got.save_request     = m_tdata[35];
            got.save_slot        = m_tdata[37:36];
            got.save_value       = m_tdata[53:38];
            if (servo_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: result transaction with none expected: %p", $time, got);
            end
            else
            begin
                want = servo_results_due.pop_front();
                bad = (got.left_pin         !== want.left_pin)         ||
                      (got.right_pin        !== want.right_pin)        ||
                      (got.period_start     !== want.period_start)     ||
                      (got.forward_setting  !== want.forward_setting)  ||
                      (got.backward_setting !== want.backward_setting) ||
                      (got.save_request     !== want.save_request)     ||
                      (got.save_slot        !== want.save_slot)        ||
                      (got.save_value       !== want.save_value);
                if (bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                 $time, want, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        item_t it;
        clk             = 1'b0;
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        items_in_flight = 0;
        mismatch_count  = 0;
        stall_cycles    = 0;
        calm            = 1'b0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table at reset configuration
        foreach (dir_rows[i])
            queue_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);
        wait_drained();

        // Reload at the right backward duty; mostly ticks, with the right
        // motor running backward and left run-state changes in between
        write_reg(REG_PERIOD_RELOAD, sh_bwd[1]);
        it = '{OP_SET_STATE, 1'b1, RS_BACKWARD, 1'b0, 1'b0};
        queue_item(it, 1'b0, '0);
        queue_random(100, 96, 4, 0, 1'b1);
        wait_drained();

        // Reload at the all-ones count, widest trim limits, no mirroring, no idling
        calm = 1'b1;
        write_reg(REG_PERIOD_RELOAD, 16'hFFFF);
        write_reg(REG_TRIM_FLOOR, 16'h0000);
        write_reg(REG_TRIM_CEILING, 16'hFFFF);
        write_reg(REG_LEFT_MIRRORED, 16'd0);
        queue_random(250, 40, 20, 35, 1'b0);
        wait_drained();
        calm = 1'b0;

        // Tight limits around the left forward duty, receiver held off
        write_reg(REG_PERIOD_RELOAD, 16'd65530);
        write_reg(REG_TRIM_FLOOR, sh_fwd[0] - 16'($urandom_range(0, 3)));
        write_reg(REG_TRIM_CEILING, sh_fwd[0] + 16'($urandom_range(0, 3)));
        write_reg(REG_LEFT_MIRRORED, 16'd1);
        hold_requests++;
        queue_random(300, 30, 20, 45, 1'b0);
        wait_drained();

        // Inverted extremes: no trim step possible
        write_reg(REG_PERIOD_RELOAD, 16'h0000);
        write_reg(REG_TRIM_FLOOR, 16'hFFFF);
        write_reg(REG_TRIM_CEILING, 16'h0000);
        write_reg(REG_LEFT_MIRRORED, 16'd0);
        queue_random(150, 50, 20, 25, 1'b0);
        wait_drained();

        // Random settings with short periods
        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_PERIOD_RELOAD, 16'($urandom_range(65400, 65535)));
            write_reg(REG_TRIM_FLOOR, 16'($urandom_range(0, 65535)));
            write_reg(REG_TRIM_CEILING, 16'($urandom_range(0, 65535)));
            write_reg(REG_LEFT_MIRRORED, 16'($urandom_range(0, 1)));
            queue_random(140, 40, 25, 30, 1'b0);
            wait_drained();
        end

        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (servo_results_due.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
